@@ src/stq_pkg.sv @@
// shared types, codes and defaults of the sorted timer queue
`default_nettype none

package stq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned TAG_BITS_DEF    = 16;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_NOTHING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_POLL_CMP
  } state_t;

  // read address select
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    idx_dec;
    logic    deq;
    logic    res_en;
    status_t res_status;
    logic    res_data;
  } stq_cmd_t;

  typedef struct packed {
    logic in_poll;
    logic full;
    logic empty;
    logic due;
    logic greater;
    logic idx_one;
  } stq_sts_t;

endpackage

`default_nettype wire

@@ src/stq_if.sv @@
// request and result channel interfaces
`default_nettype none

interface stq_in_if #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TIME_BITS-1:0] deadline;
  logic [TAG_BITS-1:0]  msg_tag;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, req_type, deadline, msg_tag, now_time, input ready);
  modport sink (input valid, req_type, deadline, msg_tag, now_time, output ready);
endinterface

interface stq_out_if #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TAG_BITS-1:0]  out_tag;
  logic [TIME_BITS-1:0] out_deadline;

  modport source (output valid, status, out_tag, out_deadline, input ready);
  modport sink (input valid, status, out_tag, out_deadline, output ready);
endinterface

`default_nettype wire

@@ src/stq_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/stq_ctrl.sv @@
// controller state machine of the sorted timer queue
`default_nettype none

module stq_ctrl import stq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_free,
  input  wire stq_sts_t sts,
  output stq_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = RD_HEAD;
    cmd.res_status = ST_NOTHING;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (sts.in_poll) begin
            if (sts.empty) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_NOTHING;
            end else begin
              cmd.latch  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_POLL_CMP;
            end
          end else if (sts.full) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ST_FULL;
          end else if (sts.empty) begin
            cmd.latch = 1'b1;
            state_nxt = S_INS_PUT;
          end else begin
            cmd.latch  = 1'b1;
            cmd.rd_sel = RD_TAIL;
            state_nxt  = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (sts.greater) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          if (sts.idx_one) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.rd_sel = RD_NEXT;
          end
        end else begin
          cmd.wr_new     = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_INSERTED;
          state_nxt      = S_IDLE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_new     = 1'b1;
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_INSERTED;
        state_nxt      = S_IDLE;
      end
      S_POLL_CMP: begin
        cmd.res_en = 1'b1;
        if (sts.due) begin
          cmd.deq        = 1'b1;
          cmd.res_data   = 1'b1;
          cmd.res_status = ST_DEQUEUED;
        end else begin
          cmd.res_status = ST_NOTHING;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/stq_datapath.sv @@
// datapath: circular sorted store, request latch and result register
`default_nettype none

module stq_datapath import stq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_req_type,
  input  wire logic [TIME_BITS-1:0] in_deadline,
  input  wire logic [TAG_BITS-1:0]  in_msg_tag,
  input  wire logic [TIME_BITS-1:0] in_now_time,
  input  wire stq_cmd_t             cmd,
  output stq_sts_t                  sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_free,
  output logic [1:0]                out_status,
  output logic [TAG_BITS-1:0]       out_tag,
  output logic [TIME_BITS-1:0]      out_deadline
);

  localparam int unsigned IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_BITS = TIME_BITS + TAG_BITS;
  localparam logic [CNT_BITS:0]   DEPTH_W  = (CNT_BITS + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_BITS-1:0] DEPTH_C  = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [CNT_BITS-1:0] OFF_ONE  = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] OFF_TWO  = CNT_BITS'(2);

  logic [IDX_BITS-1:0]  head_r;
  logic [CNT_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  idx_r;
  logic [TIME_BITS-1:0] dl_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [TAG_BITS-1:0]  out_tag_r;
  logic [TIME_BITS-1:0] out_dl_r;

  logic [CNT_BITS-1:0]  rd_off;
  logic [IDX_BITS-1:0]  rd_addr;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [ENT_BITS-1:0]  wr_data;
  logic [ENT_BITS-1:0]  rd_data;
  logic [TIME_BITS-1:0] rd_dl;
  logic [TAG_BITS-1:0]  rd_tag;

  // physical slot of a logical offset from the head
  function automatic logic [IDX_BITS-1:0] slot(input logic [IDX_BITS-1:0] base,
                                               input logic [CNT_BITS-1:0] off);
    logic [CNT_BITS:0] sum;
    sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IDX_BITS-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_off = '0;
      RD_TAIL: rd_off = count_r - OFF_ONE;
      RD_NEXT: rd_off = idx_r - OFF_TWO;
      default: rd_off = '0;
    endcase
  end

  assign rd_addr = slot(head_r, rd_off);
  assign wr_addr = slot(head_r, idx_r);
  assign wr_data = cmd.wr_shift ? rd_data : {dl_r, tag_r};

  stq_ram #(
    .WIDTH (ENT_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_shift || cmd.wr_new),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_dl  = rd_data[ENT_BITS-1:TAG_BITS];
  assign rd_tag = rd_data[TAG_BITS-1:0];

  assign sts.in_poll = (in_req_type == REQ_POLL);
  assign sts.full    = (count_r == DEPTH_C);
  assign sts.empty   = (count_r == '0);
  assign sts.due     = (rd_dl <= now_r);
  assign sts.greater = (rd_dl > dl_r);
  assign sts.idx_one = (idx_r == OFF_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        count_r <= count_r + OFF_ONE;
      end else if (cmd.deq) begin
        count_r <= count_r - OFF_ONE;
        head_r  <= slot(head_r, OFF_ONE);
      end
      if (cmd.res_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dl_r  <= in_deadline;
      tag_r <= in_msg_tag;
      now_r <= in_now_time;
      idx_r <= count_r;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - OFF_ONE;
    end
    if (cmd.res_en) begin
      out_status_r <= cmd.res_status;
      out_tag_r    <= cmd.res_data ? rd_tag : '0;
      out_dl_r     <= cmd.res_data ? rd_dl : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_free     = !out_valid_r || out_ready;
  assign out_status   = out_status_r;
  assign out_tag      = out_tag_r;
  assign out_deadline = out_dl_r;

endmodule

`default_nettype wire

@@ src/sorted_timer_queue.sv @@
// top level of the sorted timer queue
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_ch    | in  | valid / ready | req_type, deadline, msg_tag, now_time
//   out_ch   | out | valid / ready | status, out_tag, out_deadline
//
// one transaction in at a time, one result transaction out for each accepted one
// poll: head read, then compare; poll on empty queue or full insert: answered on accept
// insert: compare from the tail, each stored entry with a later deadline moved
//   up one slot through the single ram write port, then the new entry written
// reset: synchronous, active low, empties the queue at once, no clearing pass
// out_ch stalls hold the result register; in_ch is taken again once it is free
`default_nettype none

module sorted_timer_queue import stq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  stq_in_if.sink   in_ch,
  stq_out_if.source out_ch
);

  stq_cmd_t cmd;
  stq_sts_t sts;
  logic     out_free;

  // sequencer: accept, scan the store, issue the result
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store kept as a circular buffer in ascending deadline order from the head
  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req_type  (in_ch.req_type),
    .in_deadline  (in_ch.deadline),
    .in_msg_tag   (in_ch.msg_tag),
    .in_now_time  (in_ch.now_time),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_free     (out_free),
    .out_status   (out_ch.status),
    .out_tag      (out_ch.out_tag),
    .out_deadline (out_ch.out_deadline)
  );

endmodule

`default_nettype wire

@@ src/stq_checker.sv @@
// port-level checks of the sorted timer queue and their binding
`default_nettype none

module stq_checker import stq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           status,
  input wire logic [TAG_BITS-1:0]  out_tag,
  input wire logic [TIME_BITS-1:0] out_deadline
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // only a dequeue carries payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_DEQUEUED) |-> (out_tag == '0) && (out_deadline == '0))
    else $error("payload nonzero without dequeue");

  // an accepted transaction blocks input until its result shows
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("second transaction taken before result");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_timer_queue stq_checker #(
  .TIME_BITS (TIME_BITS),
  .TAG_BITS  (TAG_BITS)
) u_stq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_tag      (out_ch.out_tag),
  .out_deadline (out_ch.out_deadline)
);

`default_nettype wire
